### rtl/psh_pkg.sv
// ----------------------------------------------------------------------------
// psh_pkg
// Shared widths, constants and controller types for the polynomial string
// hash block.
// ----------------------------------------------------------------------------
`default_nettype none

package psh_pkg;

  localparam int CHAR_W        = 8;
  localparam int HASH_W        = 32;
  localparam int SUM_W         = 64;
  localparam int POS_W         = 4;
  localparam int SHIFT_PER_POS = 5;
  localparam int MAX_POS       = 13;
  localparam int CNT_W         = $clog2(SUM_W);
  localparam int SHIFT_W       = $clog2(SUM_W) + 1;

  localparam logic [HASH_W-1:0] LIMIT_RESET = HASH_W'(1);

  typedef enum logic {
    S_ACC,
    S_DIV
  } psh_state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic acc;       // add the character into the running sum
    logic start;     // add the character, load the divider, clear the string
    logic clear;     // drop the string state
    logic div_step;  // one restoring divider step
    logic out_zero;  // load a zero result
    logic out_rem;   // load the remainder as result
  } psh_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic div_last;  // current step is the final quotient bit
    logic out_free;  // result register can take a value this cycle
  } psh_status_t;

endpackage

`default_nettype wire

### rtl/psh_in_if.sv
// ----------------------------------------------------------------------------
// psh_in_if
// Character item channel: valid/ready handshake with character payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface psh_in_if
  import psh_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic signed [CHAR_W-1:0] char_code;
  logic                     last_char;
  logic                     no_char;

  modport source (output valid, output char_code, output last_char, output no_char,
                  input ready);
  modport sink   (input valid, input char_code, input last_char, input no_char,
                  output ready);
endinterface

`default_nettype wire

### rtl/psh_out_if.sv
// ----------------------------------------------------------------------------
// psh_out_if
// Result item channel: valid/ready handshake with the hash value.
// ----------------------------------------------------------------------------
`default_nettype none

interface psh_out_if
  import psh_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [HASH_W-1:0] hash_value;

  modport source (output valid, output hash_value, input ready);
  modport sink   (input valid, input hash_value, output ready);
endinterface

`default_nettype wire

### rtl/psh_ctrl.sv
// ----------------------------------------------------------------------------
// psh_ctrl
// Controller: takes character items and sequences the final divide.
// ----------------------------------------------------------------------------
`default_nettype none

module psh_ctrl
  import psh_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic        in_last_char,
  input  wire logic        in_no_char,
  output logic             in_ready,
  input  wire psh_status_t status,
  output psh_cmd_t         cmd
);

  psh_state_t state;
  psh_state_t state_next;
  logic       take;

  assign take = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_ACC;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_ACC: begin
        if (take && !in_no_char && in_last_char) begin
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (status.div_last && status.out_free) begin
          state_next = S_ACC;
        end
      end
      default: state_next = S_ACC;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    unique case (state)
      S_ACC: begin
        in_ready = status.out_free;
        if (take) begin
          priority if (in_no_char) begin
            cmd.clear    = 1'b1;
            cmd.out_zero = 1'b1;
          end else if (in_last_char) begin
            cmd.start = 1'b1;
          end else begin
            cmd.acc = 1'b1;
          end
        end
      end
      S_DIV: begin
        // Hold on the final step until the result register is free
        cmd.div_step = !(status.div_last && !status.out_free);
        cmd.out_rem  = status.div_last && status.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/psh_datapath.sv
// ----------------------------------------------------------------------------
// psh_datapath
// Running sum, position counter, restoring divider and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module psh_datapath
  import psh_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cfg_wr_en,
  input  wire logic [HASH_W-1:0]        cfg_wr_data,
  input  wire logic signed [CHAR_W-1:0] char_code,
  input  wire psh_cmd_t                 cmd,
  output psh_status_t                   status,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic [HASH_W-1:0]             hash_value
);

  logic [HASH_W-1:0] hash_limit;
  logic [SUM_W-1:0]  running_sum;
  logic [POS_W-1:0]  char_position;
  logic [SUM_W-1:0]  dividend;
  logic [HASH_W-1:0] remainder;
  logic [CNT_W-1:0]  step_cnt;

  logic              pos_live;
  logic [SHIFT_W-1:0] shift_amt;
  logic [SUM_W-1:0]  char_ext;
  logic [SUM_W-1:0]  sum_add;
  logic [HASH_W:0]   trial;
  logic [HASH_W:0]   trial_diff;
  logic [HASH_W-1:0] rem_step;

  assign pos_live  = char_position < POS_W'(MAX_POS);
  assign shift_amt = SHIFT_W'(char_position) * SHIFT_W'(SHIFT_PER_POS);
  assign char_ext  = SUM_W'(signed'(char_code));
  assign sum_add   = pos_live ? running_sum + (char_ext << shift_amt) : running_sum;

  // Restoring divide: shift in one dividend bit, subtract when it fits
  assign trial      = {remainder, dividend[SUM_W-1]};
  assign trial_diff = trial - {1'b0, hash_limit};
  assign rem_step   = (trial >= {1'b0, hash_limit}) ? trial_diff[HASH_W-1:0]
                                                    : trial[HASH_W-1:0];

  assign status.div_last = step_cnt == CNT_W'(SUM_W - 1);
  assign status.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      hash_limit <= LIMIT_RESET;
    end else if (cfg_wr_en) begin
      hash_limit <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum   <= '0;
      char_position <= '0;
    end else if (cmd.clear || cmd.start) begin
      running_sum   <= '0;
      char_position <= '0;
    end else if (cmd.acc) begin
      running_sum <= sum_add;
      if (pos_live) begin
        char_position <= char_position + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      dividend  <= sum_add;
      remainder <= '0;
    end else if (cmd.div_step) begin
      dividend  <= dividend << 1;
      remainder <= rem_step;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_cnt <= '0;
    end else if (cmd.start) begin
      step_cnt <= '0;
    end else if (cmd.div_step) begin
      step_cnt <= step_cnt + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_zero || cmd.out_rem) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_zero) begin
      hash_value <= '0;
    end else if (cmd.out_rem) begin
      hash_value <= (hash_limit == '0) ? '0 : rem_step;
    end
  end

endmodule

`default_nettype wire

### rtl/polynomial_string_hash_mod_top.sv
// ----------------------------------------------------------------------------
// polynomial_string_hash_mod_top
// Polynomial string hash (base 32, wrapping at 64 bits) reduced modulo a
// programmable limit.
// ----------------------------------------------------------------------------
// A string arrives one character item per cycle while the input channel is
// not held off; each character is sign-extended and added into a 64-bit sum
// at a weight of 32 to the power of its position, so only the first 13
// characters matter. A character that is not last gives no result. The last
// character loads a restoring divider that resolves one quotient bit per
// cycle, holding on the final bit until the result register is free, after
// which the remainder (or zero when the limit is zero) lands in the result
// register. An item with no_char set drops any partial string and gives a
// zero result. The input channel is held off while the divider runs and
// while a result waits in the output register without being taken. Write
// hash_limit (reset value 1) only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module polynomial_string_hash_mod_top
  import psh_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_wr_en,
  input  wire logic [HASH_W-1:0] cfg_wr_data,
  psh_in_if.sink                 in_ch,
  psh_out_if.source              out_ch
);

  psh_cmd_t    cmd;
  psh_status_t status;

  // Sequence item acceptance and the divide
  psh_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_ch.valid),
    .in_last_char (in_ch.last_char),
    .in_no_char   (in_ch.no_char),
    .in_ready     (in_ch.ready),
    .status       (status),
    .cmd          (cmd)
  );

  // Hold the sum, run the divider, register the result item
  psh_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .char_code   (in_ch.char_code),
    .cmd         (cmd),
    .status      (status),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .hash_value  (out_ch.hash_value)
  );

endmodule

`default_nettype wire

### verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the polynomial string hash. Directed strings cover
// the reset limit, zero and full-width limits, null strings, dropped partial
// strings and strings past the thirteenth character; random strings follow
// under random limits. Both channels idle at random. A built-in hash
// predictor, or a value from the directed table, checks every result in arrival order.
// ----------------------------------------------------------------------------

module testbench
  import psh_pkg::*;
;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int RANDOM_ITEMS  = 700;
  // A string ends with a pass through the divider; allow that and some margin.
  localparam int DRAIN_CYCLES  = 80;

  typedef enum logic {
    ROW_ITEM,
    ROW_LIMIT
  } row_kind_t;

  // One directed row: either a limit write or a run of character items.
  // For items, reps copies of ch are sent and last applies to the final copy.
  // When typed is set the final copy's result is the value given here.
  typedef struct packed {
    row_kind_t         kind;
    logic [4:0]        reps;
    logic [CHAR_W-1:0] ch;
    logic              last;
    logic              none;
    logic              typed;
    logic [HASH_W-1:0] value;
  } dir_row_t;

  localparam int DIR_ROWS = 16;

  dir_row_t dir_rows [DIR_ROWS] = '{
    // Reset limit is one, so every hash comes out zero.
    '{ROW_ITEM,  5'd1,  8'h61, 1'b1, 1'b0, 1'b1, 32'd0},
    // Null string; the character is ignored.
    '{ROW_ITEM,  5'd1,  8'h7F, 1'b0, 1'b1, 1'b1, 32'd0},
    // Zero limit forces zero whatever the sum.
    '{ROW_LIMIT, 5'd0,  8'h00, 1'b0, 1'b0, 1'b0, 32'd0},
    '{ROW_ITEM,  5'd1,  8'h7F, 1'b0, 1'b0, 1'b0, 32'd0},
    '{ROW_ITEM,  5'd1,  8'h80, 1'b1, 1'b0, 1'b1, 32'd0},
    // Full-width limit: extremes of the character.
    '{ROW_LIMIT, 5'd0,  8'h00, 1'b0, 1'b0, 1'b0, 32'hFFFF_FFFF},
    '{ROW_ITEM,  5'd1,  8'h7F, 1'b1, 1'b0, 1'b1, 32'd127},
    '{ROW_ITEM,  5'd1,  8'h80, 1'b1, 1'b0, 1'b0, 32'd0},
    // Null string flagged as last too.
    '{ROW_ITEM,  5'd1,  8'h00, 1'b1, 1'b1, 1'b1, 32'd0},
    // Partial string dropped by a null item, then a fresh one-char string.
    '{ROW_ITEM,  5'd1,  8'h05, 1'b0, 1'b0, 1'b0, 32'd0},
    '{ROW_ITEM,  5'd1,  8'hA5, 1'b0, 1'b1, 1'b1, 32'd0},
    '{ROW_ITEM,  5'd1,  8'h03, 1'b1, 1'b0, 1'b1, 32'd3},
    // Thirteen characters fill every weight; the fourteenth adds nothing.
    '{ROW_LIMIT, 5'd0,  8'h00, 1'b0, 1'b0, 1'b0, 32'd1000},
    '{ROW_ITEM,  5'd13, 8'h80, 1'b0, 1'b0, 1'b0, 32'd0},
    '{ROW_ITEM,  5'd1,  8'h7F, 1'b1, 1'b0, 1'b0, 32'd0},
    '{ROW_LIMIT, 5'd0,  8'h00, 1'b0, 1'b0, 1'b0, 32'h8000_0000}
  };

  logic              clk;
  logic              rst;
  logic              cfg_wr_en;
  logic [HASH_W-1:0] cfg_wr_data;

  psh_in_if  in_ch ();
  psh_out_if out_ch ();

  polynomial_string_hash_mod_top i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  // Predictor state: the string in progress and the current limit.
  logic [SUM_W-1:0]  hash_sum_q;
  int                hash_pos_q;
  logic [HASH_W-1:0] hash_limit_q;

  // Hash values still owed by the block, oldest first.
  logic [HASH_W-1:0] hash_expected [$];

  int  mismatches;
  int  items_sent;
  int  strings_sent;
  int  results_checked;
  int  limits_written;
  int  cycle_count;
  bit  calm;  // no idling on either side while set

  always #4 clk = ~clk;

  task automatic report_mismatch(input string what, input logic [HASH_W-1:0] got,
                                 input logic [HASH_W-1:0] want);
    $display("[%0t] mismatch, %s: got 0x%08h expected 0x%08h",
             $realtime, what, got, want);
    mismatches++;
  endtask

  // Advance the predictor by one item; give back the hash if one is due.
  task automatic hash_predict(input logic [CHAR_W-1:0] ch, input logic last,
                              input logic none, output bit emits,
                              output logic [HASH_W-1:0] hash);
    logic [SUM_W-1:0] ext;
    ext    = {{(SUM_W-CHAR_W){ch[CHAR_W-1]}}, ch};
    emits  = 1'b0;
    hash   = '0;
    if (none) begin
      // drop any partial string
      hash_sum_q = '0;
      hash_pos_q = 0;
      emits      = 1'b1;
    end else begin
      if (hash_pos_q < MAX_POS) begin
        hash_sum_q = hash_sum_q + (ext << (SHIFT_PER_POS * hash_pos_q));
        hash_pos_q++;
      end
      if (last) begin
        if (hash_limit_q != '0)
          hash = HASH_W'(hash_sum_q % {{(SUM_W-HASH_W){1'b0}}, hash_limit_q});
        hash_sum_q = '0;
        hash_pos_q = 0;
        emits      = 1'b1;
      end
    end
  endtask

  // Mostly short gaps, a few long ones, none at all in a calm phase.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55)
      return 0;
    if (r < 85)
      return $urandom_range(1, 3);
    if (r < 97)
      return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [CHAR_W-1:0] pick_char();
    case ($urandom_range(0, 11))
      0:       return 8'h80;
      1:       return 8'h7F;
      2:       return 8'hFF;
      3:       return 8'h00;
      default: return CHAR_W'($urandom);
    endcase
  endfunction

  function automatic logic [HASH_W-1:0] pick_limit();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return HASH_W'(1);
      2:       return '1;
      3:       return HASH_W'($urandom_range(2, 255));
      4:       return HASH_W'(1) << $urandom_range(1, 31);
      5:       return HASH_W'($urandom_range(2, 65535));
      6:       return HASH_W'($urandom) | 32'h8000_0000;
      default: return HASH_W'($urandom);
    endcase
  endfunction

  // Offer one item, hold it until taken, then log what the block owes.
  task automatic send_char(input logic [CHAR_W-1:0] ch, input logic last,
                           input logic none, input logic typed,
                           input logic [HASH_W-1:0] want);
    int                gap;
    bit                emits;
    logic [HASH_W-1:0] hash;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.char_code <= ch;
    in_ch.last_char <= last;
    in_ch.no_char   <= none;
    do @(posedge clk); while (!in_ch.ready);
    hash_predict(ch, last, none, emits, hash);
    if (emits) begin
      hash_expected.push_back(typed ? want : hash);
      strings_sent++;
    end
    items_sent++;
  endtask

  // Change the limit only once the block has nothing left in flight.
  task automatic write_limit(input logic [HASH_W-1:0] limit);
    in_ch.valid <= 1'b0;
    while (hash_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= limit;
    @(posedge clk);
    cfg_wr_en    <= 1'b0;
    hash_limit_q  = limit;
    limits_written++;
  endtask

  // One random string: mostly well formed, some null, some cut short.
  task automatic send_random_string();
    int r;
    int len;
    int cut;
    r = $urandom_range(0, 99);
    if (r < 5) begin
      send_char(pick_char(), 1'($urandom), 1'b1, 1'b0, '0);
      return;
    end
    case ($urandom_range(0, 19))
      0, 1, 2:          len = $urandom_range(14, 20);
      3, 4, 5, 6, 7:    len = $urandom_range(7, 13);
      default:          len = $urandom_range(1, 6);
    endcase
    // a broken string ends in a null item before its last character
    cut = len;
    if (r < 13) begin
      if (len < 2)
        len = 2;
      cut = $urandom_range(1, len - 1);
    end
    for (int i = 0; i < len; i++) begin
      if (i == cut) begin
        send_char(pick_char(), 1'($urandom), 1'b1, 1'b0, '0);
        return;
      end
      send_char(pick_char(), i == len - 1, 1'b0, 1'b0, '0);
    end
  endtask

  // Result side: check each taken item, then stall at random.
  initial begin : result_sink
    int                stall_left;
    logic [HASH_W-1:0] want;
    out_ch.ready = 1'b0;
    stall_left   = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_ch.valid && out_ch.ready) begin
        if (hash_expected.size() == 0) begin
          report_mismatch("hash with nothing pending", out_ch.hash_value, 'x);
        end else begin
          want = hash_expected.pop_front();
          if (out_ch.hash_value !== want)
            report_mismatch("hash_value", out_ch.hash_value, want);
          results_checked++;
        end
      end
      if (rst) begin
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else if (!calm && $urandom_range(0, 99) < 30) begin
        stall_left    = pick_gap();
        out_ch.ready <= (stall_left == 0);
        if (stall_left > 0)
          stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run if the block stops answering.
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL polynomial_string_hash_mod_top");
    $finish;
  end

  initial begin : stimulus
    int random_goal;
    int phase_end;

    clk             = 1'b0;
    rst             = 1'b1;
    cfg_wr_en       = 1'b0;
    cfg_wr_data     = '0;
    in_ch.valid     = 1'b0;
    in_ch.char_code = '0;
    in_ch.last_char = 1'b0;
    in_ch.no_char   = 1'b0;
    hash_sum_q      = '0;
    hash_pos_q      = 0;
    hash_limit_q    = LIMIT_RESET;
    mismatches      = 0;
    items_sent      = 0;
    strings_sent    = 0;
    results_checked = 0;
    limits_written  = 0;
    calm            = 1'b0;

    // Hold reset, then release it on a rising edge.
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: walk the table.
    for (int r = 0; r < DIR_ROWS; r++) begin
      if (dir_rows[r].kind == ROW_LIMIT) begin
        write_limit(dir_rows[r].value);
      end else begin
        for (int k = 0; k < dir_rows[r].reps; k++) begin
          send_char(dir_rows[r].ch,
                    (k == dir_rows[r].reps - 1) ? dir_rows[r].last : 1'b0,
                    dir_rows[r].none,
                    (k == dir_rows[r].reps - 1) ? dir_rows[r].typed : 1'b0,
                    dir_rows[r].value);
        end
      end
    end

    // Random part: phases under one limit each, strings always complete
    // before the limit changes. Some phases run without any idling.
    random_goal = items_sent + RANDOM_ITEMS;
    while (items_sent < random_goal) begin
      calm = 1'b0;
      write_limit(pick_limit());
      calm      = ($urandom_range(0, 3) == 0);
      phase_end = items_sent + $urandom_range(40, 100);
      while (items_sent < phase_end && items_sent < random_goal)
        send_random_string();
    end
    calm = 1'b0;

    // Drain: wait for every owed hash, then let the block settle.
    in_ch.valid <= 1'b0;
    while (hash_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d items in %0d strings under %0d limit settings.",
             items_sent, strings_sent, limits_written);
    $display("Checked %0d hash results, %0d mismatches, %0d cycles.",
             results_checked, mismatches, cycle_count);
    if (mismatches == 0)
      $display("PASS polynomial_string_hash_mod_top");
    else
      $display("FAIL polynomial_string_hash_mod_top");
    $finish;
  end

endmodule
